// ===== sv/sma_pkg.sv =====
// Shared types and constants for the moving average block.
// No dependencies; used by sma_div and simple_moving_average.
`default_nettype none

package sma_pkg;

  // width of the period register and of the divisor path
  localparam int unsigned PERIOD_W = 7;

  // period value after reset
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUB,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_OUT
  } sma_state_e;

endpackage : sma_pkg

`default_nettype wire

// ===== sv/sma_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned dividend by period.
// Depends on sma_pkg for the divisor width.
`default_nettype none

module sma_div #(
  parameter int unsigned DIVIDEND_W = 38
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DIVIDEND_W-1:0]         dividend_i,
  input  wire logic [sma_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [DIVIDEND_W-1:0]              quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);
  localparam int unsigned PW    = sma_pkg::PERIOD_W;

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [PW-1:0]         rem_q;
  logic [PW-1:0]         div_q;

  logic [PW:0]           rem_sh;
  logic [PW:0]           rem_sub;
  logic                  q_bit;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    q_bit   = (rem_sh >= {1'b0, div_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shares the shift register with the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // checks
  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule : sma_div

`default_nettype wire

// ===== sv/simple_moving_average.sv =====
// Simple moving average: top level with ring store, running sum and sequencer.
// Depends on sma_pkg and sma_div.
//
// Usage
//  - input channel (in_valid_i / in_ready_o) carries one signed sample and a
//    first_sample flag that restarts the series; in_ready_o is high only
//    while the sequencer is idle
//  - once period samples of the series have arrived, each request yields one
//    average on the output channel (out_valid_o / out_ready_i), the window sum
//    divided by period, truncated toward zero; earlier samples yield nothing
//  - the period register is written over cfg_valid_i / cfg_data_i (always
//    ready); a write restarts the series; 0 acts as 1, values above
//    MAX_PERIOD act as MAX_PERIOD
//  - a sample with a result passes the read, subtract, add, start, divide and
//    output states in order before output valid, the divide state lasting while
//    the one-bit-per-cycle divider runs; one without a result idles after add
//  - a stalled receiver holds the finished average in the output register;
//    the block still takes the next sample and only waits before loading a
//    second result into the occupied register
//  - after reset: period 5, empty window, no result pending; store contents
//    are never read before they are written in the current series
`default_nettype none

module simple_moving_average #(
  parameter int unsigned MAX_PERIOD  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sma_pkg::PERIOD_W-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          first_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      average_o
);

  localparam int unsigned PW    = sma_pkg::PERIOD_W;
  localparam int unsigned PTR_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + PTR_W;
  localparam int unsigned IDX_W = PTR_W + 2;
  localparam int unsigned PMAX  = (1 << PW) - 1;
  localparam logic [PW-1:0] PCLAMP = (MAX_PERIOD > PMAX) ? PW'(PMAX) : PW'(MAX_PERIOD);

  sma_pkg::sma_state_e state_q, state_d;

  logic [PW-1:0]          period_q;
  logic [PW-1:0]          fill_q;
  logic [PTR_W-1:0]       wp_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   full_q;
  logic                   neg_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] average_q;

  logic [SAMPLE_BITS-1:0] window_mem [MAX_PERIOD];

  logic [PW-1:0]          eff_period;
  logic [IDX_W-1:0]       old_raw;
  logic [PTR_W-1:0]       old_idx;
  logic [SUM_W-1:0]       sum_abs;
  logic [SUM_W-1:0]       quotient;
  logic [SUM_W-1:0]       quo_signed;
  logic                   div_done;
  logic                   div_start;
  logic                   in_take;
  logic                   cfg_take;
  logic                   out_load;

  // period in force: zero acts as one, clamp to the store depth
  always_comb begin
    if (period_q == '0) begin
      eff_period = PW'(1);
    end else if (period_q > PCLAMP) begin
      eff_period = PCLAMP;
    end else begin
      eff_period = period_q;
    end
  end

  // ring index of the sample leaving the window
  always_comb begin
    old_raw = IDX_W'(wp_q) + IDX_W'(MAX_PERIOD) - IDX_W'(eff_period);
    if (old_raw >= IDX_W'(MAX_PERIOD)) begin
      old_raw = old_raw - IDX_W'(MAX_PERIOD);
    end
    old_idx = old_raw[PTR_W-1:0];
  end

  assign sum_abs    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign quo_signed = neg_q ? (~quotient + SUM_W'(1)) : quotient;

  // sequencer: next state and handshakes
  always_comb begin
    state_d   = state_q;
    in_ready_o = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      sma_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sma_pkg::ST_READ;
        end
      end
      sma_pkg::ST_READ: state_d = sma_pkg::ST_SUB;
      sma_pkg::ST_SUB:  state_d = sma_pkg::ST_ADD;
      sma_pkg::ST_ADD: begin
        state_d = (fill_q >= eff_period) ? sma_pkg::ST_START : sma_pkg::ST_IDLE;
      end
      sma_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = sma_pkg::ST_DIV;
      end
      sma_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = sma_pkg::ST_OUT;
        end
      end
      sma_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = sma_pkg::ST_IDLE;
        end
      end
      default: state_d = sma_pkg::ST_IDLE;
    endcase
  end

  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window control: period, fill count, write pointer, running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= sma_pkg::PERIOD_RESET;
      fill_q   <= '0;
      wp_q     <= '0;
      sum_q    <= '0;
      full_q   <= 1'b0;
    end else begin
      if (cfg_take) begin
        period_q <= cfg_data_i;
        fill_q   <= '0;
        sum_q    <= '0;
      end else begin
        unique case (state_q)
          sma_pkg::ST_IDLE: begin
            if (in_take && first_sample_i) begin
              fill_q <= '0;
              sum_q  <= '0;
            end
          end
          sma_pkg::ST_READ: full_q <= (fill_q >= eff_period);
          sma_pkg::ST_SUB: begin
            if (full_q) begin
              sum_q  <= sum_q - SUM_W'(signed'(rd_q));
              fill_q <= eff_period;
            end else begin
              fill_q <= fill_q + PW'(1);
            end
            wp_q <= (wp_q == PTR_W'(MAX_PERIOD - 1)) ? '0 : wp_q + PTR_W'(1);
          end
          sma_pkg::ST_ADD: sum_q <= sum_q + SUM_W'(signed'(sample_q));
          default: begin
          end
        endcase
      end
    end
  end

  // sample capture and sign of the division
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
    end
    if (div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  // ring store: new sample written while the leaving one is read
  always_ff @(posedge clk_i) begin
    if (state_q == sma_pkg::ST_READ) begin
      window_mem[wp_q] <= sample_q;
      rd_q             <= window_mem[old_idx];
    end
  end

  // divider: window sum magnitude by the period in force
  sma_div #(
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs),
    .divisor_i  (eff_period),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      average_q <= quo_signed[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = signed'(average_q);

  // checks
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_period)
    else $error("fill count above period");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PTR_W'(MAX_PERIOD - 1))
    else $error("write pointer beyond store");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == sma_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (fill_q == eff_period))
    else $error("division started without a full window");

endmodule : simple_moving_average

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for simple_moving_average: directed and random samples,
// period register changes, random stalls on both channels.
// Depends on sma_pkg and simple_moving_average.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_PERIOD    = 64;
  localparam int SAMPLE_BITS   = 32;
  localparam int PERIOD_W      = sma_pkg::PERIOD_W;
  localparam int DONE_LATENCY  = 60;
  localparam int STALL_LIMIT   = 4000;
  localparam int N_PHASES      = 12;
  localparam int PHASE_ITEMS   = 160;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          restart;
    bit                            hold_for_drain;
  } sample_req_t;

  // dut ports
  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_valid_i    = 1'b0;
  logic                                cfg_ready_o;
  logic [sma_pkg::PERIOD_W-1:0]        cfg_data_i     = sma_pkg::PERIOD_RESET;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic signed [SAMPLE_BITS-1:0]       sample_i       = '0;
  logic                                first_sample_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic signed [SAMPLE_BITS-1:0]       average_o;

  // stimulus and expectations
  sample_req_t                   pending_reqs[$];
  logic signed [SAMPLE_BITS-1:0] expected_averages[$];
  int                            errors        = 0;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;
  int                            stall_cycles  = 0;

  // window predictor state
  logic signed [SAMPLE_BITS-1:0] ring[MAX_PERIOD];
  int                            wr_ptr     = 0;
  longint                        win_sum    = 0;
  int                            filled     = 0;
  logic [sma_pkg::PERIOD_W-1:0]  period_reg = sma_pkg::PERIOD_RESET;

  simple_moving_average #(
    .MAX_PERIOD  (MAX_PERIOD),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .first_sample_i (first_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_o      (average_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // advance the window by one sample; returns 1 when a full window gives an average
  function automatic bit predict_average(input logic signed [SAMPLE_BITS-1:0] smp,
                                         input logic restart,
                                         output logic signed [SAMPLE_BITS-1:0] avg);
    int p;
    int oldest;
    p = (period_reg == 0) ? 1 : (period_reg > MAX_PERIOD) ? MAX_PERIOD : int'(period_reg);
    avg = '0;
    if (restart) begin
      filled  = 0;
      win_sum = 0;
    end
    if (filled >= p) begin
      oldest  = (wr_ptr + MAX_PERIOD - p) % MAX_PERIOD;
      win_sum = win_sum - longint'(ring[oldest]);
      filled  = p;
    end else begin
      filled++;
    end
    ring[wr_ptr] = smp;
    win_sum      = win_sum + longint'(smp);
    wr_ptr       = (wr_ptr + 1) % MAX_PERIOD;
    if (filled >= p) begin
      avg = SAMPLE_BITS'(win_sum / longint'(p));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_req(input logic signed [SAMPLE_BITS-1:0] value, input logic restart,
                          input bit hold = 1'b0);
    sample_req_t req;
    req.value          = value;
    req.restart        = restart;
    req.hold_for_drain = hold;
    pending_reqs.push_back(req);
  endtask

  // wait until every request is taken and every average is back, then let the block settle
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid_i || expected_averages.size() != 0)
      @(posedge clk_i);
    repeat (DONE_LATENCY) @(posedge clk_i);
  endtask

  // period write while the block is idle; a write also restarts the series
  task automatic write_period(input logic [sma_pkg::PERIOD_W-1:0] value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_reg   = value;
    filled       = 0;
    win_sum      = 0;
    cfg_valid_i <= 1'b0;
  endtask

  // sample driver
  always @(posedge clk_i) begin : drive_samples
    sample_req_t                   req;
    logic signed [SAMPLE_BITS-1:0] avg;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (predict_average(sample_i, first_sample_i, avg))
          expected_averages.push_back(avg);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0
            && !(pending_reqs[0].hold_for_drain && expected_averages.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          req             = pending_reqs.pop_front();
          in_valid_i     <= 1'b1;
          sample_i       <= req.value;
          first_sample_i <= req.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // average monitor and receiver stalls
  always @(posedge clk_i) begin : check_averages
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_averages.size() == 0) begin
          $error("average: expected none, actual %0d", average_o);
          errors++;
        end else begin
          want = expected_averages.pop_front();
          if (average_o !== want) begin
            $error("average: expected %0d, actual %0d", want, average_o);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [sma_pkg::PERIOD_W-1:0]  periods[N_PHASES];
    logic signed [SAMPLE_BITS-1:0] smp;
    int                            eff;

    for (int i = 0; i < MAX_PERIOD; i++) ring[i] = '0;
    periods = '{7'd0, 7'd1, 7'd127, 7'd3, 7'd64, 7'd2, 7'd65, 7'd8,
                7'd5, 7'd5, 7'd5, 7'd5};
    for (int i = 8; i < N_PHASES; i++) periods[i] = PERIOD_W'($urandom_range(20, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset period of five
    send_idle_pct = 24;
    recv_idle_pct = 69;
    push_req(S_MAX, 1'b1);
    repeat (4) push_req(S_MAX, 1'b0);
    push_req(S_MIN, 1'b0);
    // negative window, pause until the earlier averages are back
    push_req(S_MIN, 1'b1, 1'b1);
    repeat (4) push_req(S_MIN, 1'b0);
    // sum of -7 over five truncates toward zero
    push_req(-1, 1'b1);
    push_req(0, 1'b0);
    push_req(0, 1'b0);
    push_req(-3, 1'b0);
    push_req(-3, 1'b0);
    // restart before the window fills
    push_req(7, 1'b1);
    push_req(8, 1'b0);
    push_req(9, 1'b1);
    repeat (4) push_req(1, 1'b0);

    // random series under several period settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_period(periods[ph]);
      send_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 69 : 0;
      recv_idle_pct = (ph < 4) ? 69 : (ph < 8) ? 24 : 0;
      eff = (periods[ph] == 0) ? 1 : (periods[ph] > MAX_PERIOD) ? MAX_PERIOD : periods[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(9))
          0:       smp = S_MAX;
          1:       smp = S_MIN;
          2:       smp = $signed($urandom_range(200)) - 100;
          3:       smp = $urandom_range(1) ? 0 : -1;
          default: smp = $urandom;
        endcase
        push_req(smp, $urandom_range(3 * eff + 20) == 0, $urandom_range(149) == 0);
      end
    end

    wait_quiet();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
